// ===== src/ptsched_pkg.sv =====
`default_nettype none

package ptsched_pkg;

  localparam int NUM_CLASSES = 16;
  localparam int MAX_MEMBERS = 255;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int CTR_W       = NUM_CLASSES - 1;
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int CMD_W       = 2;
  localparam int INTERVAL_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_MOVE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic cap_in;
    logic exec;
    logic find;
    logic load_out;
  } ctrl_cmd_t;

  // highest set bit of a positive interval, capped at the top class
  function automatic logic [CLS_W-1:0] interval_to_class(input logic [INTERVAL_W-1:0] v);
    int unsigned msb;
    msb = 0;
    for (int b = 0; b < INTERVAL_W - 1; b++) begin
      if (v[b]) begin
        msb = b;
      end
    end
    if (v[INTERVAL_W-1]) begin
      msb = 0;
    end
    if (msb > NUM_CLASSES - 1) begin
      msb = NUM_CLASSES - 1;
    end
    return CLS_W'(msb);
  endfunction

endpackage

`default_nettype wire

// ===== src/ptsched_ctrl.sv =====
`default_nettype none

module ptsched_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ptsched_pkg::ctrl_cmd_t cmd_o
);
  import ptsched_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.cap_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_FIND;
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted word not executed");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result loaded but not presented");

  a_find_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && !out_free) |=> (state_q == S_FIND && out_valid_q))
    else $error("result stage overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/ptsched_dp.sv =====
`default_nettype none

module ptsched_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ptsched_pkg::ctrl_cmd_t             cmd_i,
  input  logic [ptsched_pkg::CMD_W-1:0]      command_i,
  input  logic [ptsched_pkg::INTERVAL_W-1:0] interval_i,
  input  logic [ptsched_pkg::CLS_W-1:0]      old_class_i,
  output logic [ptsched_pkg::NUM_CLASSES-1:0] fire_mask_o,
  output logic [ptsched_pkg::CLS_W-1:0]      class_index_o,
  output logic [ptsched_pkg::CLS_W-1:0]      period_shift_o,
  output logic                               timer_running_o,
  output logic                               error_flag_o
);
  import ptsched_pkg::*;

  // captured item
  cmd_e                  cmd_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic [CLS_W-1:0]      old_q;

  // scheduler state
  logic [CTR_W-1:0]      ctr_q [NUM_CLASSES];
  logic [CNT_W-1:0]      cnt_q [NUM_CLASSES];
  logic [CLS_W-1:0]      lowest_q, lowest_d;
  logic                  any_q, any_d;

  // per-item results
  logic [NUM_CLASSES-1:0] fire_q;
  logic [CLS_W-1:0]       cls_q;
  logic                   err_q;

  logic [CTR_W-1:0]       ctr_next [NUM_CLASSES];
  logic [CTR_W:0]         incr;
  logic [NUM_CLASSES-1:0] nonzero, full, fire_d, inc_en, dec_en;
  logic [CLS_W-1:0]       new_cls, cls_d;
  logic                   old_ok, err_d, do_inc, do_dec;

  assign new_cls = interval_to_class(interval_q);
  assign incr    = (CTR_W+1)'(1) << lowest_q;
  assign old_ok  = ({1'b0, old_q} < (CLS_W+1)'(NUM_CLASSES));

  // per-class lanes: wrap counters and occupancy flags
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      logic [CTR_W:0] sum;
      sum         = {1'b0, ctr_q[i]} + incr;
      ctr_next[i] = ((sum >> i) != '0) ? '0 : sum[CTR_W-1:0];
      fire_d[i]   = (ctr_next[i] == '0);
      nonzero[i]  = (cnt_q[i] != '0);
      full[i]     = (cnt_q[i] == CNT_W'(MAX_MEMBERS));
    end
  end

  // command decode and refusal checks
  always_comb begin
    cls_d  = '0;
    err_d  = 1'b0;
    do_inc = 1'b0;
    do_dec = 1'b0;
    case (cmd_q)
      CMD_TICK: begin
      end
      CMD_ADD: begin
        cls_d = new_cls;
        if (full[new_cls]) begin
          err_d = 1'b1;
        end else begin
          do_inc = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!old_ok) begin
          err_d = 1'b1;
        end else if (!nonzero[old_q]) begin
          err_d = 1'b1;
        end else begin
          do_dec = 1'b1;
        end
      end
      CMD_MOVE: begin
        cls_d = new_cls;
        if (!old_ok) begin
          err_d = 1'b1;
        end else if (old_q != new_cls) begin
          if (!nonzero[old_q] || full[new_cls]) begin
            err_d = 1'b1;
          end else begin
            do_inc = 1'b1;
            do_dec = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      inc_en[i] = do_inc && (new_cls == CLS_W'(i));
      dec_en[i] = do_dec && (old_q == CLS_W'(i));
    end
  end

  // lowest occupied class
  always_comb begin
    lowest_d = '0;
    any_d    = |nonzero;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (nonzero[i]) begin
        lowest_d = CLS_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      cmd_q      <= cmd_e'(command_i);
      interval_q <= interval_i;
      old_q      <= old_class_i;
    end
    if (cmd_i.exec) begin
      fire_q <= (cmd_q == CMD_TICK && any_q) ? fire_d : '0;
      cls_q  <= cls_d;
      err_q  <= err_d;
    end
    if (cmd_i.load_out) begin
      fire_mask_o     <= fire_q;
      class_index_o   <= cls_q;
      period_shift_o  <= lowest_d;
      timer_running_o <= any_d;
      error_flag_o    <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        ctr_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      lowest_q <= '0;
      any_q    <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          if (cmd_q == CMD_TICK && any_q) begin
            ctr_q[i] <= ctr_next[i];
          end
          if (inc_en[i] && !dec_en[i]) begin
            cnt_q[i] <= cnt_q[i] + CNT_W'(1);
          end else if (dec_en[i] && !inc_en[i]) begin
            cnt_q[i] <= cnt_q[i] - CNT_W'(1);
          end
        end
      end
      if (cmd_i.find) begin
        lowest_q <= lowest_d;
        any_q    <= any_d;
      end
    end
  end

  a_idle_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (lowest_q == '0))
    else $error("period shift set with no class occupied");

endmodule

`default_nettype wire

// ===== src/pow2_poller_tick_scheduler.sv =====
`default_nettype none

// channel   | direction | handshake                    | word contents
// s_axis    | in        | s_axis_tvalid / s_axis_tready | command, interval, old_class
// m_axis    | out       | m_axis_tvalid / m_axis_tready | fire_mask, class_index,
//           |           |                              |   period_shift, timer_running,
//           |           |                              |   error_flag
//
// each word is captured, executed on the class lanes, then passed to the
// lowest-class priority encode that loads the output register
// the output register holds one finished result, so the next word is taken
// while it waits; a stall only blocks in the encode step until it drains
// reset clears all class counters, member counts and the lowest class at once
module pow2_poller_tick_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [33:2] interval, [37:34] old_class, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] fire_mask, [19:16] class_index, [23:20] period_shift,
  // [24] timer_running, [25] error_flag, [31:26] zero
  output logic [31:0] m_axis_tdata
);
  import ptsched_pkg::*;

  ctrl_cmd_t              ctrl_cmd;
  logic [NUM_CLASSES-1:0] fire_mask;
  logic [CLS_W-1:0]       class_index;
  logic [CLS_W-1:0]       period_shift;
  logic                   timer_running;
  logic                   error_flag;

  // sequencing: accept, execute, encode and hand over
  ptsched_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctrl_cmd)
  );

  // class lanes, member counts and result register
  ptsched_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .command_i       (s_axis_tdata[1:0]),
    .interval_i      (s_axis_tdata[33:2]),
    .old_class_i     (s_axis_tdata[37:34]),
    .fire_mask_o     (fire_mask),
    .class_index_o   (class_index),
    .period_shift_o  (period_shift),
    .timer_running_o (timer_running),
    .error_flag_o    (error_flag)
  );

  // pack the result word, highest field first
  assign m_axis_tdata = {6'b0, error_flag, timer_running, period_shift, class_index,
                         fire_mask};

endmodule

`default_nettype wire
